### rtl/prqs_pkg.sv
// Shared types and codes for the priority ready-queue scheduler.
// No dependencies; compiled first.
package prqs_pkg;

	localparam int ID_W       = 8;
	localparam int ACT_W      = 3;
	localparam int REQ_PRIO_W = 6;
	localparam int CNT_W      = 5;
	localparam int ERR_W      = 2;
	localparam int SLICE_W    = 8;

	localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_READY   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_BLOCK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_YIELD   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SETPRIO = 3'd4;
	localparam logic [ACT_W-1:0] ACT_EXIT    = 3'd5;

	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
	localparam logic [ERR_W-1:0] ERR_IDLE = 2'd2;

	localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;

	typedef struct packed {
		logic [ACT_W-1:0]      action;
		logic [ID_W-1:0]       task_id;
		logic [REQ_PRIO_W-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]       running_task;
		logic [REQ_PRIO_W-1:0] running_priority;
		logic                  switched;
		logic [CNT_W-1:0]      ready_count;
		logic [ERR_W-1:0]      error;
	} rsp_t;

endpackage

### rtl/prqs_if.sv
// Valid/ready channels for scheduler requests and results.
// Depends on prqs_pkg.
interface prqs_req_if;
	import prqs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface prqs_rsp_if;
	import prqs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler: running task, time slice and a sorted ready queue.
// Depends on prqs_pkg, prqs_if and prqs_ram.
// One request may run an ordered insert, a preemption and a requeue in turn.
// The ordered insert walks the queue RAM from the tail, one entry per cycle.
// One request at a time; the next is taken the cycle after its result is registered.
// Reset (arst_n low): idle task running, queue empty, slice count 0, quantum 4.
module priority_ready_queue_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PRIO_BITS   = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          quantum_we,
	input  logic [prqs_pkg::SLICE_W-1:0]  quantum_wdata,
	prqs_req_if.sink                      req,
	prqs_rsp_if.source                    rsp
);
	import prqs_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = PRIO_BITS;
	localparam int EW = ID_W + PW;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_YIELD     = 4'd2;
	localparam logic [3:0] S_PREEMPT   = 4'd3;
	localparam logic [3:0] S_POP       = 4'd4;
	localparam logic [3:0] S_REFILL    = 4'd5;
	localparam logic [3:0] S_INS_START = 4'd6;
	localparam logic [3:0] S_INS       = 4'd7;
	localparam logic [3:0] S_INS_HEAD  = 4'd8;
	localparam logic [3:0] S_FIN       = 4'd9;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
			input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= DEPTH_A) begin
			sum = sum - DEPTH_A;
		end
		return sum[AW-1:0];
	endfunction

	logic [3:0]         state_q;
	logic [ACT_W-1:0]   act_q;
	logic [ID_W-1:0]    id_q;
	logic [PW-1:0]      prio_q;
	logic [ID_W-1:0]    before_q;
	logic [ERR_W-1:0]   err_q;
	logic [ID_W-1:0]    run_id_q;
	logic [PW-1:0]      run_prio_q;
	logic [SLICE_W-1:0] slice_q;
	logic [SLICE_W-1:0] quantum_q;
	logic [LW-1:0]      len_q;
	logic [AW-1:0]      head_q;
	logic [ID_W-1:0]    hd_id_q;
	logic [PW-1:0]      hd_prio_q;
	logic [ID_W-1:0]    ins_id_q;
	logic [PW-1:0]      ins_prio_q;
	logic               ins_pend_q;
	logic               then_pre_q;
	logic [AW-1:0]      idx_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;

	logic [ID_W-1:0]    rd_id;
	logic [PW-1:0]      rd_prio;
	logic               ins_stop;
	logic [SLICE_W-1:0] slice_inc;
	logic [AW-1:0]      len_m1;

	prqs_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_id     = ram_rdata[EW-1:PW];
	assign rd_prio   = ram_rdata[PW-1:0];
	assign ins_stop  = (rd_prio >= ins_prio_q);
	assign slice_inc = (slice_q == SLICE_MAX) ? slice_q : slice_q + SLICE_W'(1);
	assign len_m1    = AW'(len_q - LW'(1));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// queue RAM port control; insert shifts entries toward the tail
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = {ins_id_q, ins_prio_q};
		ram_raddr = head_q;
		unique case (state_q)
			S_POP: begin
				ram_raddr = phys(head_q, AW'(1));
			end
			S_INS_START: begin
				if (len_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = phys(head_q, len_m1);
				end
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, idx_q + AW'(1));
				ram_wdata = ins_stop ? {ins_id_q, ins_prio_q} : ram_rdata;
				ram_raddr = phys(head_q, idx_q - AW'(1));
			end
			S_INS_HEAD: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_id_q     <= '0;
			run_prio_q   <= '0;
			slice_q      <= '0;
			quantum_q    <= SLICE_RESET;
			len_q        <= '0;
			head_q       <= '0;
			ins_pend_q   <= 1'b0;
			then_pre_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q    <= req.data.action;
						id_q     <= req.data.task_id;
						prio_q   <= PW'(req.data.priority_req);
						before_q <= run_id_q;
						err_q    <= ERR_NONE;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (act_q)
						ACT_TICK: begin
							slice_q <= slice_inc;
							state_q <= (slice_inc >= quantum_q) ? S_YIELD : S_FIN;
						end
						ACT_READY: begin
							if (id_q == '0) begin
								state_q <= S_PREEMPT;
							end else if (len_q == DEPTH_L) begin
								err_q   <= ERR_FULL;
								state_q <= S_PREEMPT;
							end else begin
								ins_id_q   <= id_q;
								ins_prio_q <= prio_q;
								then_pre_q <= 1'b1;
								state_q    <= S_INS_START;
							end
						end
						ACT_BLOCK, ACT_EXIT: begin
							if (run_id_q == '0) begin
								err_q   <= ERR_IDLE;
								state_q <= S_FIN;
							end else if (len_q != '0) begin
								ins_pend_q <= 1'b0;
								state_q    <= S_POP;
							end else begin
								run_id_q   <= '0;
								run_prio_q <= '0;
								slice_q    <= '0;
								state_q    <= S_FIN;
							end
						end
						ACT_YIELD: begin
							state_q <= S_YIELD;
						end
						ACT_SETPRIO: begin
							if (run_id_q != '0) begin
								run_prio_q <= prio_q;
							end
							state_q <= S_PREEMPT;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_YIELD: begin
					slice_q <= '0;
					if (len_q == '0) begin
						state_q <= S_FIN;
					end else if (run_id_q == '0) begin
						ins_pend_q <= 1'b0;
						state_q    <= S_POP;
					end else if (run_prio_q <= hd_prio_q) begin
						ins_pend_q <= 1'b1;
						ins_id_q   <= run_id_q;
						ins_prio_q <= run_prio_q;
						state_q    <= S_POP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PREEMPT: begin
					if (len_q != '0 && (run_id_q == '0 || run_prio_q < hd_prio_q)) begin
						state_q <= S_YIELD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_POP: begin
					run_id_q   <= hd_id_q;
					run_prio_q <= hd_prio_q;
					head_q     <= phys(head_q, AW'(1));
					len_q      <= len_q - LW'(1);
					slice_q    <= '0;
					state_q    <= S_REFILL;
				end
				S_REFILL: begin
					hd_id_q   <= rd_id;
					hd_prio_q <= rd_prio;
					state_q   <= ins_pend_q ? S_INS_START : S_FIN;
				end
				S_INS_START: begin
					ins_pend_q <= 1'b0;
					if (len_q == '0) begin
						hd_id_q    <= ins_id_q;
						hd_prio_q  <= ins_prio_q;
						len_q      <= LW'(1);
						then_pre_q <= 1'b0;
						state_q    <= then_pre_q ? S_PREEMPT : S_FIN;
					end else begin
						idx_q   <= len_m1;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (ins_stop) begin
						len_q      <= len_q + LW'(1);
						then_pre_q <= 1'b0;
						state_q    <= then_pre_q ? S_PREEMPT : S_FIN;
					end else if (idx_q == '0) begin
						state_q <= S_INS_HEAD;
					end else begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_INS_HEAD: begin
					hd_id_q    <= ins_id_q;
					hd_prio_q  <= ins_prio_q;
					len_q      <= len_q + LW'(1);
					then_pre_q <= 1'b0;
					state_q    <= then_pre_q ? S_PREEMPT : S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q            <= 1'b1;
						rsp_q.running_task     <= run_id_q;
						rsp_q.running_priority <= REQ_PRIO_W'(run_prio_q);
						rsp_q.switched         <= (run_id_q != before_q);
						rsp_q.ready_count      <= CNT_W'(len_q);
						rsp_q.error            <= err_q;
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= DEPTH_L)
		else $error("ready queue length beyond depth");

	a_idle_prio: assert property (@(posedge clk) disable iff (!arst_n)
		run_id_q == '0 |-> run_prio_q == '0)
		else $error("idle task running at nonzero priority");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_START || state_q == S_INS) |-> len_q < DEPTH_L)
		else $error("insert started on a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> len_q != '0)
		else $error("dispatch from an empty queue");
endmodule

### rtl/prqs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
